### rtl/core/ccfd_pkg.sv
// Shared types, codes and constants of the COBS checksum frame decoder.
package ccfd_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 1024;
  localparam int CAP_W               = 11;
  localparam int CAP_RESET           = 1024;
  localparam int MIN_FRAME           = 4;
  localparam int BYTE_W              = 8;
  localparam int SUM_W               = 16;
  localparam int COUNT_W             = 10;
  localparam int STATUS_W            = 3;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 3'd0,
    STATUS_EMPTY = 3'd1,
    STATUS_SHORT = 3'd2,
    STATUS_LONG  = 3'd3,
    STATUS_CODE  = 3'd4,
    STATUS_SUM   = 3'd5
  } status_t;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [BYTE_W-1:0]   data_byte;
    status_t             status;
    logic [COUNT_W-1:0]  payload_count;
  } result_t;

endpackage

### rtl/core/ccfd_in_reg.sv
// Input register stage for received bytes.
module ccfd_in_reg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        byte_valid,
  output logic                        byte_stall,
  input  logic [ccfd_pkg::BYTE_W-1:0] in_byte,
  input  logic                        advance,
  output logic                        item_valid,
  output logic [ccfd_pkg::BYTE_W-1:0] item_byte
);

  assign byte_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!byte_stall) begin
      item_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      item_byte <= in_byte;
    end
  end

endmodule

### rtl/core/ccfd_frame_core.sv
// Frame state, COBS countdown, two-byte hold, checksum and end-of-frame checks.
module ccfd_frame_core #(
  parameter int MAX_FRAME_BYTES = ccfd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [ccfd_pkg::CAP_W-1:0]  cfg_data,
  input  logic                        item_valid,
  input  logic [ccfd_pkg::BYTE_W-1:0] item_byte,
  input  logic                        advance,
  output logic                        res_produce,
  output ccfd_pkg::result_t           res
);

  localparam int LW  = $clog2(MAX_FRAME_BYTES + 3);
  localparam int MCW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CW  = (ccfd_pkg::CAP_W > MCW) ? ccfd_pkg::CAP_W : MCW;
  localparam int XW  = ((LW > CW) ? LW : CW) + 1;

  logic [ccfd_pkg::CAP_W-1:0]  decode_capacity;
  logic [ccfd_pkg::BYTE_W-1:0] zero_countdown, zero_countdown_next;
  logic [LW-1:0]               frame_length, frame_length_next;
  logic [ccfd_pkg::BYTE_W-1:0] hold_bytes [2];
  logic [ccfd_pkg::BYTE_W-1:0] hold0_next, hold1_next;
  logic [1:0]                  hold_fill, hold_fill_next;
  logic [ccfd_pkg::SUM_W-1:0]  running_sum, running_sum_next;

  logic                        consume;
  logic [CW-1:0]               cap;
  logic [XW-1:0]               len_x, cap_x;
  logic [ccfd_pkg::BYTE_W-1:0] cd_dec, dec;

  assign consume = item_valid && advance;

  always_comb begin
    if (CW'(decode_capacity) > CW'(MAX_FRAME_BYTES)) begin
      cap = CW'(MAX_FRAME_BYTES);
    end else begin
      cap = CW'(decode_capacity);
    end
    len_x = XW'(frame_length);
    cap_x = XW'(cap);
  end

  always_comb begin
    zero_countdown_next = zero_countdown;
    frame_length_next   = frame_length;
    hold0_next          = hold_bytes[0];
    hold1_next          = hold_bytes[1];
    hold_fill_next      = hold_fill;
    running_sum_next    = running_sum;
    res_produce         = 1'b0;
    res.kind            = ccfd_pkg::KIND_DATA;
    res.data_byte       = '0;
    res.status          = ccfd_pkg::STATUS_OK;
    res.payload_count   = '0;
    cd_dec              = zero_countdown - 8'd1;
    dec                 = item_byte;

    if (item_byte == '0) begin
      res_produce = 1'b1;
      res.kind    = ccfd_pkg::KIND_STATUS;
      priority if (frame_length == '0) begin
        res.status = ccfd_pkg::STATUS_EMPTY;
      end else if (frame_length < LW'(ccfd_pkg::MIN_FRAME)) begin
        res.status = ccfd_pkg::STATUS_SHORT;
      end else if ((len_x - XW'(1)) > cap_x) begin
        res.status = ccfd_pkg::STATUS_LONG;
      end else if (zero_countdown != 8'd1) begin
        res.status = ccfd_pkg::STATUS_CODE;
      end else if (running_sum != {hold_bytes[0], hold_bytes[1]}) begin
        res.status = ccfd_pkg::STATUS_SUM;
      end else begin
        res.status        = ccfd_pkg::STATUS_OK;
        res.payload_count = ccfd_pkg::COUNT_W'(frame_length - LW'(3));
      end
      zero_countdown_next = '0;
      frame_length_next   = '0;
      hold_fill_next      = '0;
      running_sum_next    = '0;
    end else begin
      if (frame_length != LW'(MAX_FRAME_BYTES + 2)) begin
        frame_length_next = frame_length + LW'(1);
      end
      if (frame_length == '0) begin
        zero_countdown_next = item_byte;
      end else begin
        if (cd_dec == '0) begin
          zero_countdown_next = item_byte;
          dec                 = '0;
        end else begin
          zero_countdown_next = cd_dec;
        end
        if (hold_fill == 2'd2) begin
          running_sum_next = running_sum + ccfd_pkg::SUM_W'(hold_bytes[0]);
          if (len_x <= cap_x) begin
            res_produce   = 1'b1;
            res.data_byte = hold_bytes[0];
          end
          hold0_next = hold_bytes[1];
          hold1_next = dec;
        end else begin
          if (hold_fill[0]) begin
            hold1_next = dec;
          end else begin
            hold0_next = dec;
          end
          hold_fill_next = hold_fill + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_capacity <= ccfd_pkg::CAP_W'(ccfd_pkg::CAP_RESET);
      zero_countdown  <= '0;
      frame_length    <= '0;
      hold_fill       <= '0;
      running_sum     <= '0;
    end else begin
      if (cfg_valid) begin
        decode_capacity <= cfg_data;
      end
      if (consume) begin
        zero_countdown <= zero_countdown_next;
        frame_length   <= frame_length_next;
        hold_fill      <= hold_fill_next;
        running_sum    <= running_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      hold_bytes[0] <= hold0_next;
      hold_bytes[1] <= hold1_next;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) hold_fill <= 2'd2)
    else $error("hold fill above two");

  a_empty_hold: assert property (@(posedge clk) disable iff (rst)
    frame_length == '0 |-> hold_fill == '0)
    else $error("hold not empty at frame start");

  a_delim_clear: assert property (@(posedge clk) disable iff (rst)
    consume && item_byte == '0 |=> frame_length == '0 && running_sum == '0)
    else $error("frame state not cleared after delimiter");

  a_data_full: assert property (@(posedge clk) disable iff (rst)
    res_produce && res.kind == ccfd_pkg::KIND_DATA |-> hold_fill == 2'd2)
    else $error("data emitted from partial hold");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    XW'(frame_length) <= XW'(MAX_FRAME_BYTES + 2))
    else $error("frame length above saturation");

endmodule

### rtl/core/ccfd_out_reg.sv
// Result register with stall handling.
module ccfd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_produce,
  input  ccfd_pkg::result_t res,
  output logic              advance,
  output logic              result_valid,
  input  logic              result_stall,
  output ccfd_pkg::result_t result
);

  assign advance = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= res_produce;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_produce) begin
      result <= res;
    end
  end

endmodule

### rtl/core/cobs_checksum_frame_decoder.sv
// Top level of the COBS checksum frame decoder.
// Accepts one received byte per cycle and returns results via the input and
// result registers: a decoded data byte once a newer byte pushes it out of the
// two-byte checksum hold, or one end-of-frame status when a zero delimiter
// arrives. Many bytes yield no result. The pace is one byte per cycle, set by
// the single result register; a stall on the result side holds the input
// register and stalls the byte side. The capacity register may be written at
// any time the decoder is idle; cfg_ready is always high with no clearing pass.
module cobs_checksum_frame_decoder #(
  parameter int MAX_FRAME_BYTES = ccfd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ccfd_pkg::CAP_W-1:0]    cfg_data,
  input  logic                          byte_valid,
  output logic                          byte_stall,
  input  logic [ccfd_pkg::BYTE_W-1:0]   in_byte,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          kind,
  output logic [ccfd_pkg::BYTE_W-1:0]   data_byte,
  output logic [ccfd_pkg::STATUS_W-1:0] status,
  output logic [ccfd_pkg::COUNT_W-1:0]  payload_count
);

  logic                        advance;
  logic                        item_valid;
  logic [ccfd_pkg::BYTE_W-1:0] item_byte;
  logic                        res_produce;
  ccfd_pkg::result_t           res;
  ccfd_pkg::result_t           result;

  assign cfg_ready = 1'b1;

  ccfd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .in_byte    (in_byte),
    .advance    (advance),
    .item_valid (item_valid),
    .item_byte  (item_byte)
  );

  ccfd_frame_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_frame_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_byte   (item_byte),
    .advance     (advance),
    .res_produce (res_produce),
    .res         (res)
  );

  ccfd_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .res_produce  (item_valid && res_produce),
    .res          (res),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign kind          = result.kind;
  assign data_byte     = result.data_byte;
  assign status        = result.status;
  assign payload_count = result.payload_count;

endmodule
